FILE: design/tjs_pkg.sv
// Package for the timestamp jitter smoother: payload types, sequencer states,
// constants and the per-n fit weight function. No dependencies.
package tjs_pkg;

  localparam int WINDOW_DEF = 16;
  localparam int WW = 256;
  localparam logic [31:0] GAP_RESET = 32'd3000;

  typedef struct packed {
    logic signed [63:0] timestamp;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] filtered_timestamp;
    logic               corrected;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_LOOP, S_LOOP2, S_LOOP3, S_VAR1, S_VAR2, S_LHS1, S_LHS2,
    S_LHS3, S_RHS, S_DIV, S_FINAL, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_ADD, OP_SUB, OP_MUL
  } alu_op_t;

  typedef struct packed {
    alu_op_t       op;
    logic [WW-1:0] a;
    logic [WW-1:0] b;
  } alu_req_t;

  function automatic logic signed [31:0] fit_weight(input int n, input int i);
    int u;
    begin
      u = 2 * i - (n - 1);
      fit_weight = 32'(2 * (n + 1) * (n + 2) + 6 * u * (n + 2) + 15 * u * u
                       - 5 * n * n + 5);
    end
  endfunction

  function automatic logic [WW-1:0] sx64(input logic [63:0] v);
    sx64 = {{(WW - 64){v[63]}}, v};
  endfunction

endpackage

FILE: design/tjs_alu.sv
// Shared 256-bit arithmetic unit: add, subtract, multiply (modulo 2^256).
// The multiply accumulates 32x32 partial products. Uses tjs_pkg.
module tjs_alu (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tjs_pkg::alu_req_t req,
  output logic              done,
  output logic [255:0]      result
);
  import tjs_pkg::*;

  logic [255:0] a, b, acc;
  logic [2:0]   ia, jb;
  logic         busy;
  logic [63:0]  pp;
  logic [255:0] pp_sh;
  logic [3:0]   pos;

  assign pos = {1'b0, ia} + {1'b0, jb};
  assign pp = 64'(a[ia*32 +: 32]) * 64'(b[jb*32 +: 32]);
  assign pp_sh = 256'(pp) << (pos[2:0] * 32);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      unique case (req.op)
        OP_ADD: begin
          result <= req.a + req.b;
          done <= 1'b1;
        end
        OP_SUB: begin
          result <= req.a - req.b;
          done <= 1'b1;
        end
        OP_MUL: begin
          a <= req.a;
          b <= req.b;
          acc <= '0;
          ia <= '0;
          jb <= '0;
          busy <= 1'b1;
        end
        default: done <= 1'b1;
      endcase
    end else if (busy) begin
      if (!pos[3]) acc <= acc + pp_sh;
      jb <= jb + 3'd1;
      if (jb == 3'd7) begin
        ia <= ia + 3'd1;
        if (ia == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
          result <= pos[3] ? acc : acc + pp_sh;
        end
      end
    end
  end
endmodule

FILE: design/tjs_div.sv
// Restoring divider: 256-bit magnitude by a 32-bit divisor, one quotient bit
// per cycle, rounds half away from zero. Uses tjs_pkg.
module tjs_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [255:0] num,
  input  logic [31:0]  den,
  output logic         done,
  output logic [255:0] quot
);
  import tjs_pkg::*;

  logic [255:0] m, q;
  logic [32:0]  rem;
  logic [32:0]  trial;
  logic [7:0]   cnt;
  logic         busy, neg;
  logic [255:0] qr;

  assign trial = {rem[31:0], m[255]};
  assign qr = q + 256'(({rem[31:0], 1'b0}) >= {1'b0, den});

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      neg <= num[255];
      m <= num[255] ? -num : num;
      rem <= '0;
      q <= '0;
      cnt <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      m <= m << 1;
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        q <= {q[254:0], 1'b1};
      end else begin
        rem <= trial;
        q <= {q[254:0], 1'b0};
      end
      if (cnt == 8'd255) busy <= 1'b0;
      else cnt <= cnt + 8'd1;
    end else if (cnt == 8'd255) begin
      cnt <= '0;
      done <= 1'b1;
      quot <= neg ? -qr : qr;
    end
  end
endmodule

FILE: design/timestamp_jitter_smoother.sv
// Top level of the timestamp jitter smoother: APB register, history memory,
// sequencer around the shared ALU and the divider. Uses tjs_pkg, tjs_alu, tjs_div.
//
//  channel | direction | payload
//  in      | input     | timestamp, restart
//  out     | output    | filtered_timestamp, corrected
//  apb     | input     | frame_gap at address 0
//
// With n >= 3 stored entries a request runs two multiplies per entry on the shared
// ALU, five more for the deviation test, the 256-step divide and the output
// handshake. Windows of one or two entries go from S_PREP straight to S_OUT.
// Reset clears the fill count, sets the warm-up flag and loads GAP_RESET into
// frame_gap; history needs no clearing.
// in_stall is high from acceptance until the result is taken off the output.
module timestamp_jitter_smoother #(
  parameter int WINDOW = tjs_pkg::WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tjs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tjs_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tjs_pkg::*;

  localparam int IW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic signed [63:0] SMAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SMIN = {1'b1, {63{1'b0}}};

  logic [31:0] frame_gap;
  logic signed [63:0] hist [WINDOW];
  logic [CW-1:0] fill;
  logic warm_up;
  state_t state, state_next;

  logic signed [63:0] v, prev;
  logic [IW-1:0] idx;
  logic [255:0] s, sd, sd2, d, lhs, var_r;
  logic [31:0] dd, dd49;
  logic close_hit;

  alu_req_t req;
  logic alu_start, alu_done, div_start, div_done;
  logic [255:0] alu_res, quot;

  assign pready = 1'b1;
  assign prdata = frame_gap;

  always_ff @(posedge clk) begin
    if (rst) frame_gap <= GAP_RESET;
    else if (psel && penable && pwrite && paddr == 2'd0) frame_gap <= pwdata;
  end

  tjs_alu u_alu (.clk, .rst, .start(alu_start), .req, .done(alu_done), .result(alu_res));
  tjs_div u_div (.clk, .rst, .start(div_start), .num(s), .den(dd), .done(div_done),
                 .quot);

  function automatic logic [63:0] absd(input logic signed [63:0] a, b);
    absd = (a >= b) ? 64'(a - b) : 64'(b - a);
  endfunction
  function automatic logic signed [63:0] addg(input logic signed [63:0] a,
                                              input logic [31:0] g);
    addg = (a > SMAX - $signed({32'd0, g})) ? SMAX : a + $signed({32'd0, g});
  endfunction
  function automatic logic tclose(input logic [63:0] dv, input logic [31:0] g);
    logic [66:0] lim;
    lim = 67'(g) * 67'd5;
    tclose = (67'(dv) < lim) && (67'(dv) * 67'd6 < lim);
  endfunction

  logic [CW-1:0] n;
  logic signed [63:0] ts;
  logic [CW-1:0] fill0;
  logic fr0;
  logic signed [31:0] wgt;
  assign ts = in_data.timestamp;
  assign fill0 = in_data.restart ? '0 : fill;
  assign fr0 = in_data.restart ? 1'b1 : warm_up;
  assign n = fill;
  assign wgt = fit_weight(int'(n), int'(idx));

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    alu_start = 1'b0;
    div_start = 1'b0;
    req = '{op: OP_ADD, a: '0, b: '0};
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_PREP;
      S_PREP:  state_next = (n >= CW'(3)) ? S_LOOP : S_OUT;
      S_LOOP: begin
        alu_start = 1'b1;
        req = '{op: OP_MUL, a: {{224{wgt[31]}}, wgt}, b: d};
        state_next = S_LOOP2;
      end
      S_LOOP2: if (alu_done) begin
        alu_start = 1'b1;
        req = '{op: OP_MUL, a: d, b: d};
        state_next = S_LOOP3;
      end
      S_LOOP3: if (alu_done) state_next = (32'(idx) == 32'(n) - 1) ? S_VAR1 : S_LOOP;
      S_VAR1: begin
        alu_start = 1'b1;
        req = '{op: OP_MUL, a: 256'(n), b: sd2};
        state_next = S_VAR2;
      end
      S_VAR2: if (alu_done) begin
        alu_start = 1'b1;
        req = '{op: OP_MUL, a: sd, b: sd};
        state_next = S_LHS1;
      end
      S_LHS1: if (alu_done) begin
        alu_start = 1'b1;
        req = '{op: OP_MUL, a: 256'(625 * int'(n) * int'(n)), b: s};
        state_next = S_LHS2;
      end
      S_LHS2: if (alu_done) begin
        alu_start = 1'b1;
        req = '{op: OP_MUL, a: alu_res, b: s};
        state_next = S_LHS3;
      end
      S_LHS3: if (alu_done) begin
        alu_start = 1'b1;
        req = '{op: OP_MUL, a: 256'(64'(dd49) * 64'(dd49)), b: var_r};
        state_next = S_RHS;
      end
      S_RHS: if (alu_done) begin
        div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: if (div_done) state_next = S_FINAL;
      S_FINAL: state_next = S_OUT;
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic gt;
  logic signed [255:0] fitw;
  assign gt = $signed(lhs) > $signed(alu_res);
  assign fitw = $signed(sx64(v)) + $signed(quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      warm_up <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          logic signed [63:0] vv;
          vv = ts;
          if (fr0 && fill0 == '0 && (ts == SMAX || ts == SMIN)) vv = '0;
          if (fill0 != '0) begin
            if (67'(absd(hist[IW'(fill0 - 1)], ts)) > 67'(frame_gap) * 67'd10)
              vv = addg(hist[IW'(fill0 - 1)], frame_gap);
          end
          v <= vv;
          if (fill0 >= CW'(WINDOW)) begin
            for (int k = 0; k < WINDOW - 1; k++) hist[k] <= hist[k + 1];
            hist[WINDOW - 1] <= vv;
            fill <= CW'(WINDOW);
            warm_up <= 1'b0;
          end else begin
            hist[IW'(fill0)] <= vv;
            fill <= fill0 + 1'b1;
            warm_up <= (fill0 + 1'b1 == CW'(WINDOW)) ? 1'b0 : fr0;
          end
        end
        S_PREP: begin
          s <= '0; sd <= '0; sd2 <= '0;
          idx <= '0;
          dd <= 32'(2 * int'(n) * (int'(n) + 1) * (int'(n) + 2));
          dd49 <= 32'(98 * int'(n) * (int'(n) + 1) * (int'(n) + 2));
          d <= sx64(hist[0]) - sx64(v);
          prev <= hist[IW'(n - 2)];
          close_hit <= 1'b0;
          out_data.filtered_timestamp <= v;
          out_data.corrected <= 1'b0;
          if (n == CW'(2) && tclose(absd(hist[0], hist[1]), frame_gap)) begin
            out_data.filtered_timestamp <= addg(hist[0], frame_gap);
            out_data.corrected <= addg(hist[0], frame_gap) != v;
          end
          if (n < CW'(3)) out_valid <= 1'b1;
        end
        S_LOOP2: if (alu_done) begin
          s <= s + alu_res;
          sd <= sd + d;
        end
        S_LOOP3: if (alu_done) begin
          sd2 <= sd2 + alu_res;
          if (32'(idx) != 32'(n) - 1) begin
            idx <= idx + 1'b1;
            d <= sx64(hist[idx + 1'b1]) - sx64(v);
          end
        end
        S_VAR2: if (alu_done) var_r <= alu_res;
        S_LHS1: if (alu_done) var_r <= var_r - alu_res;
        S_RHS: if (alu_done) begin
          close_hit <= gt || tclose(absd(prev, v), frame_gap);
        end
        S_FINAL: begin
          if (close_hit) begin
            logic signed [63:0] r;
            if (fitw > $signed(sx64(SMAX))) r = SMAX;
            else if (fitw < $signed(sx64(SMIN))) r = SMIN;
            else r = fitw[63:0];
            out_data.filtered_timestamp <= r;
            out_data.corrected <= r != v;
          end
          out_valid <= 1'b1;
        end
        S_OUT: if (!out_stall) out_valid <= 1'b0;
        default: ;
      endcase
      if (state == S_LHS3 && alu_done) lhs <= alu_res;
    end
  end

  assign in_stall = state != S_IDLE;
endmodule

FILE: dv/tb_timestamp_jitter_smoother.sv
// Self-checking testbench for timestamp_jitter_smoother: directed and random frame
// timestamps across several frame_gap settings, checked against an in-bench predictor.
// Depends on tjs_pkg and the timestamp_jitter_smoother RTL.
module tb_timestamp_jitter_smoother;
  timeunit 1ns;
  timeprecision 1ps;
  import tjs_pkg::*;

  localparam int NWIN = 16;
  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam logic signed [63:0] TS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] TS_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [1:0] ADDR_FRAME_GAP = 2'd0;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;

  timestamp_jitter_smoother DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  in_item_t  pending_q[$];
  out_item_t expected_q[$];

  // smoother model state
  logic [31:0] gap_cfg;
  logic signed [63:0] win_hist[NWIN];
  int win_fill;
  bit win_first;

  int errors, n_sent, n_checked, n_corrected, n_restart;
  bit no_idle;
  longint cycles;
  logic signed [63:0] last_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] abs_diff(logic signed [63:0] a, logic signed [63:0] b);
    abs_diff = (a >= b) ? 64'(a - b) : 64'(b - a);
  endfunction

  function automatic logic signed [63:0] plus_gap(logic signed [63:0] a);
    logic signed [63:0] lim;
    lim = TS_MAX - $signed({32'b0, gap_cfg});
    plus_gap = (a > lim) ? TS_MAX : a + $signed({32'b0, gap_cfg});
  endfunction

  function automatic bit is_close(logic signed [63:0] a, logic signed [63:0] b);
    logic [63:0] d, lim, d6;
    d = abs_diff(a, b);
    lim = 64'(gap_cfg) * 64'd5;
    d6 = d * 64'd6;
    is_close = (d < lim) && (d6 < lim);
  endfunction

  function automatic logic signed [63:0] quad_fit(int n, logic signed [63:0] newest);
    logic signed [255:0] yl, d, s, sd, sd2, vv, lhs, rhs, num, r, hi, lo;
    logic [255:0] mu, q, rem, ddw;
    longint u, nn, dd, w;
    bit neg;
    yl = newest;
    s = 0; sd = 0; sd2 = 0;
    nn = n;
    dd = 2 * nn * (nn + 1) * (nn + 2);
    for (int i = 0; i < n; i++) begin
      d = {{192{win_hist[i][63]}}, win_hist[i]} - yl;
      u = 2 * i - (nn - 1);
      w = 2 * (nn + 1) * (nn + 2) + 6 * u * (nn + 2) + 15 * u * u - 5 * nn * nn + 5;
      num = w;
      s = s + num * d;
      sd = sd + d;
      sd2 = sd2 + d * d;
    end
    num = nn;
    vv = num * sd2 - sd * sd;
    num = 625 * nn * nn;
    lhs = num * s * s;
    num = 2401 * dd * dd;
    rhs = num * vv;
    if (lhs > rhs || is_close(win_hist[n - 2], newest)) begin
      neg = s[255];
      mu = neg ? 256'(-s) : 256'(s);
      ddw = 256'(dd);
      q = mu / ddw;
      rem = mu % ddw;
      if (2 * rem >= ddw) q = q + 1;
      r = neg ? -$signed(q) : $signed(q);
      r = r + yl;
      hi = TS_MAX;
      lo = TS_MIN;
      if (r > hi) quad_fit = TS_MAX;
      else if (r < lo) quad_fit = TS_MIN;
      else quad_fit = r[63:0];
    end else begin
      quad_fit = newest;
    end
  endfunction

  function automatic out_item_t smooth(in_item_t it);
    logic signed [63:0] ts, v, res;
    out_item_t o;
    ts = it.timestamp;
    v = ts;
    if (it.restart) begin
      win_fill = 0;
      win_first = 1'b1;
    end
    if (win_first && win_fill == 0 && (ts == TS_MAX || ts == TS_MIN)) v = 0;
    if (win_fill > 0)
      if (abs_diff(win_hist[win_fill - 1], ts) > 64'(gap_cfg) * 64'd10)
        v = plus_gap(win_hist[win_fill - 1]);
    if (win_fill >= NWIN) begin
      for (int i = 0; i < NWIN - 1; i++) win_hist[i] = win_hist[i + 1];
      win_fill = NWIN - 1;
    end
    win_hist[win_fill] = v;
    win_fill++;
    if (win_fill == NWIN) win_first = 1'b0;
    res = v;
    if (win_fill == 2) begin
      if (is_close(win_hist[0], win_hist[1])) res = plus_gap(win_hist[0]);
    end else if (win_fill >= 3) begin
      res = quad_fit(win_fill, v);
    end
    o.filtered_timestamp = res;
    o.corrected = (res != v);
    smooth = o;
  endfunction

  // request driver
  int in_idle;
  always @(posedge clk) begin
    bit nv;
    nv = in_valid;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(smooth(pending_q[0]));
        pending_q.delete(0);
        n_sent++;
        nv = 1'b0;
      end
      if (!(in_valid && in_stall)) begin
        nv = 1'b0;
        if (in_idle > 0) begin
          in_idle--;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
          in_idle = $urandom_range(1, 8) - 1;
        end else if (pending_q.size() > 0) begin
          nv = 1'b1;
          in_data <= pending_q[0];
        end
      end
    end
    in_valid <= nv;
  end

  // result monitor
  int out_idle;
  always @(posedge clk) begin
    out_item_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result: actual %h/%b", $time,
                   out_data.filtered_timestamp, out_data.corrected);
          errors++;
        end else begin
          e = expected_q[0];
          expected_q.delete(0);
          n_checked++;
          if (e.corrected) n_corrected++;
          if (out_data.filtered_timestamp !== e.filtered_timestamp) begin
            $display("%0t filtered_timestamp mismatch: expected %h actual %h", $time,
                     e.filtered_timestamp, out_data.filtered_timestamp);
            errors++;
          end
          if (out_data.corrected !== e.corrected) begin
            $display("%0t corrected mismatch: expected %b actual %b", $time,
                     e.corrected, out_data.corrected);
            errors++;
          end
        end
      end
      if (out_idle > 0) begin
        out_idle--;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_idle = $urandom_range(1, 8) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_gap(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_FRAME_GAP; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    gap_cfg = value;
  endtask

  task automatic send(logic signed [63:0] ts, bit rs);
    in_item_t it;
    it.timestamp = ts;
    it.restart = rs;
    if (rs) n_restart++;
    pending_q.push_back(it);
    last_sent = ts;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0 || in_valid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // mostly steady frame cadence, with outliers, duplicates, noise and restarts
  task automatic send_random(int count);
    logic signed [63:0] g, jit, nx;
    int r;
    for (int k = 0; k < count; k++) begin
      g = $signed({32'b0, gap_cfg});
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send($signed({$urandom, $urandom}), 1'b1);
      end else if (r < 4) begin
        send($urandom_range(0, 1) ? TS_MAX : TS_MIN, 1'b1);
      end else if (r < 8) begin
        nx = last_sent + g * $urandom_range(11, 40) * ($urandom_range(0, 1) ? 1 : -1);
        send(nx, 1'b0);
      end else if (r < 15) begin
        jit = (g * 5 / 6 > 0) ? $signed(64'($urandom_range(0, 32'(g * 5 / 6)))) : 0;
        send(last_sent + jit, 1'b0);
      end else if (r < 18) begin
        send($signed({$urandom, $urandom}), 1'b0);
      end else begin
        jit = $signed(64'($urandom_range(0, 32'(g / 2)))) - g / 4;
        send(last_sent + g + jit, 1'b0);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    gap_cfg = GAP_RESET;
    win_fill = 0; win_first = 1'b1;
    errors = 0; n_sent = 0; n_checked = 0; n_corrected = 0; n_restart = 0;
    no_idle = 1'b0; cycles = 0; last_sent = 0; in_idle = 0; out_idle = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme first samples, jumps, saturation, close pairs, flat window
    send(TS_MIN, 1'b0);
    send(3000, 1'b0);
    send(1000, 1'b0);
    send(9000, 1'b0);
    send(500000, 1'b0);
    send(TS_MAX, 1'b1);
    send(100, 1'b0);
    send(TS_MAX - 100, 1'b1);
    send(TS_MIN, 1'b0);
    send(TS_MAX, 1'b0);
    send(-64'sd5000, 1'b1);
    send(-64'sd2000, 1'b0);
    send(1000, 1'b0);
    send(4000, 1'b0);
    send(4100, 1'b0);
    send(0, 1'b1);
    for (int k = 0; k < 5; k++) send(0, 1'b0);
    send(2000, 1'b0);
    send(TS_MIN + 10, 1'b1);
    send(TS_MIN, 1'b0);
    send(TS_MIN + 5, 1'b0);
    drain();

    write_gap(32'd1);
    send(64'sd77, 1'b1);
    send_random(180);
    drain();
    write_gap(32'hFFFF_FFFF);
    send($signed({$urandom, $urandom}), 1'b1);
    send_random(180);
    drain();
    write_gap($urandom_range(1, 32'hFFFF_FFFF));
    send(0, 1'b1);
    send_random(200);
    drain();
    write_gap(GAP_RESET);
    send(0, 1'b1);
    send_random(120);
    drain();
    no_idle = 1'b1;
    send_random(120);
    drain();

    $display("Sent %0d frame timestamps, checked %0d (%0d corrected, %0d restarts).",
             n_sent, n_checked, n_corrected, n_restart);
    $display("Covered 5 gap settings with random stalls, then a back-to-back tail.");
    if (errors == 0 && expected_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
